// ----- design/scs_pkg.sv -----
// scs_pkg: command and status codes, field widths and crc constants
// shared by the spool controller, its crc unit and byte store; no dependencies

package scs_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned CRC_W    = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    K_BEGIN  = 3'd0,
    K_WRITE  = 3'd1,
    K_FINISH = 3'd2,
    K_ABORT  = 3'd3,
    K_READ   = 3'd4,
    K_REWIND = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ARG   = 2'd1,
    ST_STATE = 2'd2,
    ST_CRC   = 2'd3
  } status_e;

endpackage

// ----- design/scs_crc.sv -----
// scs_crc: one-byte update of a reflected crc-32, eight shift steps unrolled
// depends on scs_pkg for the polynomial and widths

module scs_crc import scs_pkg::*; (
  input  logic [CRC_W-1:0]  crc_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic [CRC_W-1:0]  crc_o
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_i ^ {{(CRC_W-BYTE_W){1'b0}}, byte_i};
    for (int i = 0; i < BYTE_W; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    crc_o = c;
  end

endmodule

// ----- design/scs_store.sv -----
// scs_store: payload byte memory, one write port and one registered read port
// depends on scs_pkg for the byte width

module scs_store import scs_pkg::*; #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/crc_checked_spool_controller.sv -----
// crc_checked_spool_controller: crc-checked payload spool, top level
// depends on scs_pkg, scs_crc and scs_store
//
// usage
//   a transaction is accepted at a rising edge with start_i high and busy_o
//   low; kind_i selects begin, write byte, finish, abort, read byte or rewind
//   busy_o stays low, so a new transaction can be taken in every cycle
//   each transaction gives one result in the following cycle, marked by
//   done_o for exactly one cycle; the receiver cannot stall it
//   throughput is one transaction per cycle; the byte store has a single
//   read port, whose registered data feeds read_data_o, gated by
//   read_valid_o, in the result cycle
//   a write stores its byte and folds it into the crc in the accept cycle
//   a read issues the store read in the accept cycle, and the byte appears
//   with the strobe
//   reset clears session flags and positions, sets the crc accumulator to ones;
//   the byte store is not cleared, as only bytes of a finished payload are read

module crc_checked_spool_controller import scs_pkg::*; #(
  parameter int unsigned CAPACITY = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [LEN_W-1:0]    total_length_i,
  input  logic [CRC_W-1:0]    expected_crc_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   read_data_o,
  output logic                read_valid_o,
  output logic                spool_ready_o,
  output logic                write_open_o
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam logic [31:0] CAP_W  = 32'(CAPACITY);

  logic              writing_q, writing_d;
  logic              ready_q, ready_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CRC_W-1:0]  crch_q, crch_d;
  logic [LEN_W-1:0]  wpos_q, wpos_d;
  logic [LEN_W-1:0]  rpos_q, rpos_d;
  logic [CRC_W-1:0]  acc_q, acc_d;

  logic                done_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                rvalid_q, rvalid_d;

  logic              we, re;
  logic [CRC_W-1:0]  acc_upd;
  logic [BYTE_W-1:0] rdata;
  logic              accept;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;

  scs_crc u_crc (
    .crc_i  (acc_q),
    .byte_i (data_byte_i),
    .crc_o  (acc_upd)
  );

  scs_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (ADDR_W'(wpos_q)),
    .wdata_i (data_byte_i),
    .re_i    (re),
    .raddr_i (ADDR_W'(rpos_q)),
    .rdata_o (rdata)
  );

  always_comb begin
    writing_d = writing_q;
    ready_d   = ready_q;
    len_d     = len_q;
    crch_d    = crch_q;
    wpos_d    = wpos_q;
    rpos_d    = rpos_q;
    acc_d     = acc_q;
    status_d  = ST_OK;
    rvalid_d  = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    if (accept) begin
      case (kind_e'(kind_i))
        K_BEGIN: begin
          if (total_length_i == '0 || 32'(total_length_i) > CAP_W) begin
            status_d = ST_ARG;
          end else if (writing_q) begin
            status_d = ST_STATE;
          end else begin
            len_d     = total_length_i;
            crch_d    = expected_crc_i;
            rpos_d    = '0;
            wpos_d    = '0;
            acc_d     = CRC_ONES;
            ready_d   = 1'b0;
            writing_d = 1'b1;
          end
        end
        K_WRITE: begin
          if (!writing_q || wpos_q >= len_q || 32'(wpos_q) >= CAP_W) begin
            status_d = ST_ARG;
          end else begin
            we     = 1'b1;
            acc_d  = acc_upd;
            wpos_d = wpos_q + 1'b1;
          end
        end
        K_FINISH: begin
          if (!writing_q || wpos_q != len_q) begin
            status_d = ST_STATE;
          end else if ((acc_q ^ CRC_ONES) != crch_q) begin
            writing_d = 1'b0;
            ready_d   = 1'b0;
            rpos_d    = '0;
            wpos_d    = '0;
            len_d     = '0;
            crch_d    = '0;
            status_d  = ST_CRC;
          end else begin
            writing_d = 1'b0;
            ready_d   = 1'b1;
            rpos_d    = '0;
          end
        end
        K_ABORT: begin
          writing_d = 1'b0;
          ready_d   = 1'b0;
          rpos_d    = '0;
          wpos_d    = '0;
          len_d     = '0;
          crch_d    = '0;
        end
        K_READ: begin
          if (!ready_q || writing_q) begin
            status_d = ST_STATE;
          end else if (rpos_q < len_q && 32'(rpos_q) < CAP_W) begin
            re       = 1'b1;
            rvalid_d = 1'b1;
            rpos_d   = rpos_q + 1'b1;
          end
        end
        K_REWIND: begin
          if (!ready_q || writing_q) begin
            status_d = ST_STATE;
          end else begin
            rpos_d = '0;
          end
        end
        default: begin
          status_d = ST_ARG;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      writing_q <= 1'b0;
      ready_q   <= 1'b0;
      len_q     <= '0;
      crch_q    <= '0;
      wpos_q    <= '0;
      rpos_q    <= '0;
      acc_q     <= CRC_ONES;
      done_q    <= 1'b0;
      status_q  <= ST_OK;
      rvalid_q  <= 1'b0;
    end else begin
      writing_q <= writing_d;
      ready_q   <= ready_d;
      len_q     <= len_d;
      crch_q    <= crch_d;
      wpos_q    <= wpos_d;
      rpos_q    <= rpos_d;
      acc_q     <= acc_d;
      done_q    <= accept;
      status_q  <= status_d;
      rvalid_q  <= rvalid_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign read_valid_o  = rvalid_q;
  assign read_data_o   = rvalid_q ? rdata : '0;
  assign spool_ready_o = ready_q && !writing_q;
  assign write_open_o  = writing_q;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted transaction gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without a transaction");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> done_o && status_o == ST_OK)
    else $error("read byte without ok result");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    writing_q |-> wpos_q <= len_q)
    else $error("write position past length");

  a_read_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> ready_q && !writing_q)
    else $error("store read outside a ready spool");
`endif

endmodule
